>>> rtl/mpld_pkg.sv
// Shared types and constants for the multi-pin latching debouncer.
`default_nettype none

package mpld_pkg;

   localparam int TICK_W      = 32;
   localparam int PIN_FIELD_W = 3;
   localparam int MASK_W      = 8;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 32;

   localparam logic [TICK_W-1:0] SETTLE_TICKS_RESET = 32'd50;

   // Item operations
   localparam logic OP_SAMPLE = 1'b0;
   localparam logic OP_CLEAR  = 1'b1;

   // Configuration register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_SETTLE_TICKS = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_LATCH_MASK   = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_INVERT_MASK  = 2'd2;

   typedef struct packed {
      logic                   operation;
      logic [PIN_FIELD_W-1:0] pin_index;
      logic                   raw_level;
      logic [TICK_W-1:0]      now_ticks;
   } item_type;

   typedef struct packed {
      logic [PIN_FIELD_W-1:0] out_pin;
      logic                   pressed;
      logic                   settled;
      logic                   held;
   } result_type;

endpackage

`default_nettype wire

>>> rtl/mpld_pin_bank.sv
// Per-pin debounce state and the read-modify-write update of one pin per item.
`default_nettype none

module mpld_pin_bank #(
   parameter int NUM_PINS = 8
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           commit,
   input  wire mpld_pkg::item_type             item,
   input  wire logic [mpld_pkg::TICK_W-1:0]    settle_ticks,
   input  wire logic [mpld_pkg::MASK_W-1:0]    latch_mask,
   input  wire logic [mpld_pkg::MASK_W-1:0]    invert_mask,
   output mpld_pkg::result_type                result
);
   import mpld_pkg::*;

   localparam int IDX_W = (NUM_PINS > 1) ? $clog2(NUM_PINS) : 1;
   localparam int EXT_W = (IDX_W > PIN_FIELD_W) ? IDX_W : PIN_FIELD_W;

   logic [NUM_PINS-1:0] stable_ff;
   logic [NUM_PINS-1:0] cand_ff;
   logic [NUM_PINS-1:0] settled_ff;
   logic [TICK_W-1:0]   mark_ff [NUM_PINS];

   logic [EXT_W-1:0]  pin_ext;
   logic [IDX_W-1:0]  idx;
   logic              in_range;

   logic              stable_in;
   logic              cand_in;
   logic              settled_in;
   logic [TICK_W-1:0] mark_in;
   logic              held;

   assign pin_ext  = EXT_W'(item.pin_index);
   assign idx      = pin_ext[IDX_W-1:0];
   assign in_range = (32'(item.pin_index) < 32'(NUM_PINS));

   always_comb begin
      logic raw;
      raw        = ~(item.raw_level ^ invert_mask[item.pin_index]);
      stable_in  = stable_ff[idx];
      cand_in    = cand_ff[idx];
      settled_in = settled_ff[idx];
      mark_in    = mark_ff[idx];
      held       = 1'b0;
      if (item.operation == OP_CLEAR) begin
         stable_in  = 1'b0;
         cand_in    = 1'b0;
         settled_in = 1'b0;
         mark_in    = '0;
      end else if (latch_mask[item.pin_index] && settled_ff[idx] && stable_ff[idx]) begin
         held = 1'b1;
      end else begin
         // lost the settled level: drop the flag and start a fresh run
         if (settled_in && (raw != stable_in)) begin
            settled_in = 1'b0;
            mark_in    = '0;
         end
         if ((raw != cand_in) || (mark_in == '0)) begin
            mark_in = item.now_ticks;
            cand_in = raw;
         end
         if ((item.now_ticks - mark_in) > settle_ticks) begin
            stable_in  = cand_in;
            settled_in = 1'b1;
            mark_in    = '0;
         end
      end
   end

   always_comb begin
      result.out_pin = item.pin_index;
      result.pressed = in_range & stable_in;
      result.settled = in_range & settled_in;
      result.held    = in_range & held;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stable_ff  <= '0;
         cand_ff    <= '0;
         settled_ff <= '0;
         for (int i = 0; i < NUM_PINS; i++) begin
            mark_ff[i] <= '0;
         end
      end else if (commit && in_range) begin
         stable_ff[idx]  <= stable_in;
         cand_ff[idx]    <= cand_in;
         settled_ff[idx] <= settled_in;
         mark_ff[idx]    <= mark_in;
      end
   end

   a_held_means_latched: assert property (@(posedge clock) disable iff (reset)
      commit && result.held |-> result.pressed && result.settled
                                && latch_mask[item.pin_index])
      else $error("held result without a latched settled press");

   a_clear_zeroes_pin: assert property (@(posedge clock) disable iff (reset)
      commit && in_range && (item.operation == OP_CLEAR)
      |=> (stable_ff[$past(idx)] == 1'b0) && (settled_ff[$past(idx)] == 1'b0)
          && (cand_ff[$past(idx)] == 1'b0) && (mark_ff[$past(idx)] == '0))
      else $error("clear left state on the pin");

   a_state_quiet: assert property (@(posedge clock) disable iff (reset)
      !commit |=> $stable(stable_ff) && $stable(settled_ff) && $stable(cand_ff))
      else $error("pin state changed without a committed item");

endmodule

`default_nettype wire

>>> rtl/multi_pin_latching_debouncer.sv
// Top level: configuration registers, input register, pin bank and result register.
`default_nettype none

// Debounces a bank of NUM_PINS switch inputs one sample item at a time and
// returns one result item for each input item, in order. The block takes one
// item per cycle, back to back, as long as results are taken; a result is
// offered once its item has moved from the input register through the per-pin
// read-modify-write into the result register. Rate is set by the update of the
// addressed pin's state, written back as each item commits, so items for the
// same pin may follow each other without gaps. Pin indexes at or above
// NUM_PINS change nothing and report zero pressed, settled and held flags.
// Configuration must be written through csr_we/csr_index/csr_wdata only while
// the block is idle; the block itself does not enforce this. The state is
// ready right after reset with no clearing pass.
module multi_pin_latching_debouncer #(
   parameter int NUM_PINS = 8
) (
   input  wire logic                                clock,
   input  wire logic                                reset,

   input  wire logic                                req_valid,
   output      logic                                req_ready,
   input  wire logic                                req_operation,
   input  wire logic [mpld_pkg::PIN_FIELD_W-1:0]    req_pin_index,
   input  wire logic                                req_raw_level,
   input  wire logic [mpld_pkg::TICK_W-1:0]         req_now_ticks,

   output      logic                                rsp_valid,
   input  wire logic                                rsp_ready,
   output      logic [mpld_pkg::PIN_FIELD_W-1:0]    rsp_out_pin,
   output      logic                                rsp_pressed,
   output      logic                                rsp_settled,
   output      logic                                rsp_held,

   input  wire logic                                csr_we,
   input  wire logic [mpld_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire logic [mpld_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import mpld_pkg::*;

   logic [TICK_W-1:0] settle_ticks_ff;
   logic [MASK_W-1:0] latch_mask_ff;
   logic [MASK_W-1:0] invert_mask_ff;

   logic       s1_valid_ff;
   item_type   s1_item_ff;
   logic       rsp_valid_ff;
   result_type rsp_ff;

   logic       advance;
   logic       req_take;
   result_type bank_result;

   assign advance   = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || advance;
   assign req_take  = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         settle_ticks_ff <= SETTLE_TICKS_RESET;
         latch_mask_ff   <= '0;
         invert_mask_ff  <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_SETTLE_TICKS: settle_ticks_ff <= csr_wdata[TICK_W-1:0];
            CSR_LATCH_MASK:   latch_mask_ff   <= csr_wdata[MASK_W-1:0];
            CSR_INVERT_MASK:  invert_mask_ff  <= csr_wdata[MASK_W-1:0];
            default: ;
         endcase
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_take) begin
         s1_valid_ff <= 1'b1;
      end else if (advance) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_item_ff.operation <= req_operation;
         s1_item_ff.pin_index <= req_pin_index;
         s1_item_ff.raw_level <= req_raw_level;
         s1_item_ff.now_ticks <= req_now_ticks;
      end
   end

   mpld_pin_bank #(
      .NUM_PINS (NUM_PINS)
   ) u_pin_bank (
      .clock        (clock),
      .reset        (reset),
      .commit       (advance),
      .item         (s1_item_ff),
      .settle_ticks (settle_ticks_ff),
      .latch_mask   (latch_mask_ff),
      .invert_mask  (invert_mask_ff),
      .result       (bank_result)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= bank_result;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_out_pin = rsp_ff.out_pin;
   assign rsp_pressed = rsp_ff.pressed;
   assign rsp_settled = rsp_ff.settled;
   assign rsp_held    = rsp_ff.held;

endmodule

`default_nettype wire
